@@ rtl/core/odq_pkg.sv @@
// ----------------------------------------------------------------------------
// odq_pkg
// shared constants, types and level tables for the ordered dither quantizer
// ----------------------------------------------------------------------------
package odq_pkg;

    localparam int DITHER_CELLS = 16;
    localparam int MAX_LEVELS   = 16;
    localparam int NUM_CH       = 3;

    localparam int PIX_W    = 8;
    localparam int CELL_W   = 4;
    localparam int LCNT_W   = 5;
    localparam int IDX_W    = 8;
    localparam int CENTRE_W = 9;
    localparam int LVL_W    = $clog2(MAX_LEVELS);
    localparam int ACC_W    = CENTRE_W + LVL_W;
    localparam int PROD_W   = CELL_W + CENTRE_W;
    localparam int THR_W    = PROD_W + 1;
    localparam int GB_W     = 2 * LCNT_W;
    localparam int SUM_W    = LVL_W + GB_W;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [LCNT_W-1:0] RESET_LEVELS = LCNT_W'(6);
    localparam logic [LCNT_W-1:0] LEVEL_MIN    = LCNT_W'(2);
    localparam logic [IDX_W-1:0]  INDEX_MAX    = {IDX_W{1'b1}};

    typedef logic [CENTRE_W-1:0] centre_t;
    typedef centre_t [MAX_LEVELS-1:0] centre_row_t;

    typedef enum logic [1:0] {
        REG_RED   = 2'd0,
        REG_GREEN = 2'd1,
        REG_BLUE  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [LCNT_W-1:0] red_levels;
        logic [LCNT_W-1:0] green_levels;
        logic [LCNT_W-1:0] blue_levels;
        logic [GB_W-1:0]   gb_product;
        logic              busy;
    } cfg_state_t;

    function automatic logic [LCNT_W-1:0] clamp_levels(input logic [LCNT_W-1:0] v);
        logic [LCNT_W-1:0] r;
        r = v;
        if (v < LEVEL_MIN) begin
            r = LEVEL_MIN;
        end else if (v > LCNT_W'(MAX_LEVELS)) begin
            r = LCNT_W'(MAX_LEVELS);
        end
        return r;
    endfunction

    // floor(256 / L)
    function automatic logic [7:0] levels_quot(input logic [LCNT_W-1:0] l);
        logic [7:0] r;
        case (l)
            5'd2:    r = 8'd128;
            5'd3:    r = 8'd85;
            5'd4:    r = 8'd64;
            5'd5:    r = 8'd51;
            5'd6:    r = 8'd42;
            5'd7:    r = 8'd36;
            5'd8:    r = 8'd32;
            5'd9:    r = 8'd28;
            5'd10:   r = 8'd25;
            5'd11:   r = 8'd23;
            5'd12:   r = 8'd21;
            5'd13:   r = 8'd19;
            5'd14:   r = 8'd18;
            5'd15:   r = 8'd17;
            5'd16:   r = 8'd16;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // 256 mod L
    function automatic logic [LVL_W-1:0] levels_rem(input logic [LCNT_W-1:0] l);
        logic [LVL_W-1:0] r;
        case (l)
            5'd3:    r = LVL_W'(1);
            5'd5:    r = LVL_W'(1);
            5'd6:    r = LVL_W'(4);
            5'd7:    r = LVL_W'(4);
            5'd9:    r = LVL_W'(4);
            5'd10:   r = LVL_W'(6);
            5'd11:   r = LVL_W'(3);
            5'd12:   r = LVL_W'(4);
            5'd13:   r = LVL_W'(9);
            5'd14:   r = LVL_W'(4);
            5'd15:   r = LVL_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // floor(128 / L)
    function automatic logic [6:0] levels_half(input logic [LCNT_W-1:0] l);
        logic [6:0] r;
        case (l)
            5'd2:    r = 7'd64;
            5'd3:    r = 7'd42;
            5'd4:    r = 7'd32;
            5'd5:    r = 7'd25;
            5'd6:    r = 7'd21;
            5'd7:    r = 7'd18;
            5'd8:    r = 7'd16;
            5'd9:    r = 7'd14;
            5'd10:   r = 7'd12;
            5'd11:   r = 7'd11;
            5'd12:   r = 7'd10;
            5'd13:   r = 7'd9;
            5'd14:   r = 7'd9;
            5'd15:   r = 7'd8;
            5'd16:   r = 7'd8;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/odq_cfg.sv @@
// ----------------------------------------------------------------------------
// odq_cfg
// level count registers and level centre tables, rebuilt one entry per cycle
// ----------------------------------------------------------------------------
module odq_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [odq_pkg::PADDR_W-1:0]          paddr,
    input  logic [odq_pkg::PDATA_W-1:0]          pwdata,
    output logic [odq_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    output odq_pkg::cfg_state_t                  cfg,
    output odq_pkg::centre_row_t                 centres [odq_pkg::NUM_CH]
);

    logic [odq_pkg::LCNT_W-1:0] levels_reg  [odq_pkg::NUM_CH];
    logic [odq_pkg::LCNT_W-1:0] levels_next [odq_pkg::NUM_CH];
    logic [odq_pkg::ACC_W-1:0]  quot_reg    [odq_pkg::NUM_CH];
    logic [odq_pkg::ACC_W-1:0]  quot_next   [odq_pkg::NUM_CH];
    logic [odq_pkg::LVL_W-1:0]  rem_reg     [odq_pkg::NUM_CH];
    logic [odq_pkg::LVL_W-1:0]  rem_next    [odq_pkg::NUM_CH];
    odq_pkg::centre_row_t       centre_reg  [odq_pkg::NUM_CH];
    logic [odq_pkg::LVL_W-1:0]  cnt_reg;
    logic [odq_pkg::LVL_W-1:0]  cnt_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic [odq_pkg::GB_W-1:0]   gb_reg;
    logic                       wr_en;
    logic                       start;
    odq_pkg::reg_idx_t          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = odq_pkg::reg_idx_t'(paddr[odq_pkg::PADDR_W-1:2]);

    always_comb begin
        prdata = '0;
        case (reg_idx)
            odq_pkg::REG_RED, odq_pkg::REG_GREEN, odq_pkg::REG_BLUE: begin
                prdata = odq_pkg::PDATA_W'(levels_reg[reg_idx]);
            end
            default: ;
        endcase
    end

    always_comb begin
        levels_next = levels_reg;
        start       = 1'b0;
        if (wr_en) begin
            case (reg_idx)
                odq_pkg::REG_RED, odq_pkg::REG_GREEN, odq_pkg::REG_BLUE: begin
                    levels_next[reg_idx] =
                        odq_pkg::clamp_levels(pwdata[odq_pkg::LCNT_W-1:0]);
                    start = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // running floor(j*256/L) as quotient and remainder
    for (genvar ch = 0; ch < odq_pkg::NUM_CH; ch++) begin : g_acc
        logic [odq_pkg::LCNT_W-1:0] rsum;
        logic                       carry;

        assign rsum  = odq_pkg::LCNT_W'(rem_reg[ch])
                     + odq_pkg::LCNT_W'(odq_pkg::levels_rem(levels_reg[ch]));
        assign carry = (rsum >= levels_reg[ch]);

        always_comb begin
            if (start) begin
                quot_next[ch] = '0;
                rem_next[ch]  = '0;
            end else if (busy_reg) begin
                quot_next[ch] = quot_reg[ch]
                              + odq_pkg::ACC_W'(odq_pkg::levels_quot(levels_reg[ch]))
                              + odq_pkg::ACC_W'(carry);
                rem_next[ch]  = carry ? odq_pkg::LVL_W'(rsum - levels_reg[ch])
                                      : odq_pkg::LVL_W'(rsum);
            end else begin
                quot_next[ch] = quot_reg[ch];
                rem_next[ch]  = rem_reg[ch];
            end
        end

        always_ff @(posedge aclk) begin
            if (busy_reg) begin
                centre_reg[ch][cnt_reg] <= odq_pkg::centre_t'(quot_reg[ch]
                    + odq_pkg::ACC_W'(odq_pkg::levels_half(levels_reg[ch])));
            end
        end

        assign centres[ch] = centre_reg[ch];
    end

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + odq_pkg::LVL_W'(1);
            if (cnt_reg == odq_pkg::LVL_W'(odq_pkg::MAX_LEVELS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= '{default: odq_pkg::RESET_LEVELS};
            quot_reg   <= '{default: '0};
            rem_reg    <= '{default: '0};
            cnt_reg    <= '0;
            busy_reg   <= 1'b1;
            gb_reg     <= '0;
        end else begin
            levels_reg <= levels_next;
            quot_reg   <= quot_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            gb_reg     <= odq_pkg::GB_W'(levels_reg[odq_pkg::REG_GREEN])
                        * odq_pkg::GB_W'(levels_reg[odq_pkg::REG_BLUE]);
        end
    end

    assign cfg.red_levels   = levels_reg[odq_pkg::REG_RED];
    assign cfg.green_levels = levels_reg[odq_pkg::REG_GREEN];
    assign cfg.blue_levels  = levels_reg[odq_pkg::REG_BLUE];
    assign cfg.gb_product   = gb_reg;
    assign cfg.busy         = busy_reg;

endmodule

@@ rtl/core/odq_lane.sv @@
// ----------------------------------------------------------------------------
// odq_lane
// one channel quantizer: segment search, then dither threshold and level
// ----------------------------------------------------------------------------
module odq_lane (
    input  logic                          aclk,
    input  logic                          en1,
    input  logic                          en2,
    input  logic [odq_pkg::LCNT_W-1:0]    levels,
    input  logic                          low_dither,
    input  logic [odq_pkg::PIX_W-1:0]     value,
    input  logic [odq_pkg::CELL_W-1:0]    dcell,
    input  odq_pkg::centre_row_t          centres,
    output logic [odq_pkg::LVL_W-1:0]     level
);

    typedef struct packed {
        logic [odq_pkg::PIX_W-1:0]  value;
        logic [odq_pkg::CELL_W-1:0] dcell;
        odq_pkg::centre_t           base;
        odq_pkg::centre_t           span;
        logic [odq_pkg::LVL_W-1:0]  lvl_lo;
        logic                       dith;
    } seg_t;

    logic [odq_pkg::MAX_LEVELS-1:0] ge;
    logic [odq_pkg::LVL_W-1:0]      top_idx;
    logic                           top;
    seg_t                           s1_next;
    seg_t                           s1_reg;
    logic [odq_pkg::PROD_W-1:0]     prod;
    logic [odq_pkg::THR_W-1:0]      thr;
    logic                           up;
    logic [odq_pkg::LVL_W-1:0]      level_next;
    logic [odq_pkg::LVL_W-1:0]      level_reg;

    for (genvar j = 0; j < odq_pkg::MAX_LEVELS; j++) begin : g_cmp
        assign ge[j] = (odq_pkg::CENTRE_W'(value) >= centres[j]);
    end

    assign top_idx = odq_pkg::LVL_W'(levels - odq_pkg::LCNT_W'(1));
    assign top     = ge[top_idx];

    always_comb begin
        s1_next.value  = value;
        s1_next.dcell  = dcell;
        s1_next.base   = '0;
        s1_next.span   = centres[0];
        s1_next.lvl_lo = '0;
        s1_next.dith   = low_dither;
        if (ge[0]) begin
            if (top) begin
                s1_next.lvl_lo = top_idx;
                s1_next.dith   = 1'b0;
            end else begin
                for (int j = 0; j < odq_pkg::MAX_LEVELS - 1; j++) begin
                    if (ge[j] && !ge[j+1] && (odq_pkg::LCNT_W'(j + 1) < levels)) begin
                        s1_next.base   = centres[j];
                        s1_next.span   = centres[j+1] - centres[j];
                        s1_next.lvl_lo = odq_pkg::LVL_W'(j);
                        s1_next.dith   = 1'b1;
                    end
                end
            end
        end
    end

    assign prod = odq_pkg::PROD_W'(s1_reg.dcell) * odq_pkg::PROD_W'(s1_reg.span);
    assign thr  = odq_pkg::THR_W'(prod / odq_pkg::DITHER_CELLS)
                + odq_pkg::THR_W'(s1_reg.base);
    assign up   = s1_reg.dith && (odq_pkg::THR_W'(s1_reg.value) > thr);
    assign level_next = s1_reg.lvl_lo + odq_pkg::LVL_W'(up);

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg <= s1_next;
        end
        if (en2) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

@@ rtl/core/odq_merge.sv @@
// ----------------------------------------------------------------------------
// odq_merge
// combines the three channel levels into a saturated color cube index
// ----------------------------------------------------------------------------
module odq_merge (
    input  logic                          aclk,
    input  logic                          en,
    input  odq_pkg::cfg_state_t           cfg,
    input  logic [odq_pkg::LVL_W-1:0]     red_level,
    input  logic [odq_pkg::LVL_W-1:0]     green_level,
    input  logic [odq_pkg::LVL_W-1:0]     blue_level,
    output logic [odq_pkg::IDX_W-1:0]     color_index
);

    logic [odq_pkg::SUM_W-1:0] sum;
    logic [odq_pkg::IDX_W-1:0] index_next;
    logic [odq_pkg::IDX_W-1:0] index_reg;

    assign sum = odq_pkg::SUM_W'(red_level) * odq_pkg::SUM_W'(cfg.gb_product)
               + odq_pkg::SUM_W'(green_level) * odq_pkg::SUM_W'(cfg.blue_levels)
               + odq_pkg::SUM_W'(blue_level);

    assign index_next = (sum > odq_pkg::SUM_W'(odq_pkg::INDEX_MAX))
                      ? odq_pkg::INDEX_MAX : odq_pkg::IDX_W'(sum);

    always_ff @(posedge aclk) begin
        if (en) begin
            index_reg <= index_next;
        end
    end

    assign color_index = index_reg;

endmodule

@@ rtl/core/rgb_ordered_dither_quantizer.sv @@
// ----------------------------------------------------------------------------
// rgb_ordered_dither_quantizer
// ordered dither of an RGB pixel into a color cube index, one lane per channel
// ----------------------------------------------------------------------------
//  channel   ports                              transaction
//  s_        s_valid/s_ready, rgb + cell        one pixel
//  m_        m_valid/m_ready, m_color_index     one color cube index
//  apb       psel/penable/pwrite/paddr/pwdata   level count registers
//
//  three pipeline stages: segment search, dither threshold, index merge
//  one pixel per cycle while s_ready is high; m_valid rises once the pixel
//  reaches the merge register; after reset and every level write the centre
//  tables are rebuilt one entry per cycle, all 16 entries, with s_ready low
//  each stage holds while the one after it is full and stalled
// ----------------------------------------------------------------------------
module rgb_ordered_dither_quantizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [odq_pkg::PADDR_W-1:0]   paddr,
    input  logic [odq_pkg::PDATA_W-1:0]   pwdata,
    output logic [odq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [odq_pkg::PIX_W-1:0]     s_red_in,
    input  logic [odq_pkg::PIX_W-1:0]     s_green_in,
    input  logic [odq_pkg::PIX_W-1:0]     s_blue_in,
    input  logic [odq_pkg::CELL_W-1:0]    s_dither_cell,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [odq_pkg::IDX_W-1:0]     m_color_index
);

    odq_pkg::cfg_state_t       cfg;
    odq_pkg::centre_row_t      centres [odq_pkg::NUM_CH];
    logic [odq_pkg::LVL_W-1:0] red_level;
    logic [odq_pkg::LVL_W-1:0] green_level;
    logic [odq_pkg::LVL_W-1:0] blue_level;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic                      v1_next;
    logic                      v2_next;
    logic                      v3_next;
    logic                      rdy1;
    logic                      rdy2;
    logic                      rdy3;

    odq_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .centres (centres)
    );

    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1 && !cfg.busy;

    assign v1_next = rdy1 ? (s_valid && s_ready) : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    odq_lane u_lane_red (
        .aclk       (aclk),
        .en1        (rdy1),
        .en2        (rdy2),
        .levels     (cfg.red_levels),
        .low_dither (1'b1),
        .value      (s_red_in),
        .dcell      (s_dither_cell),
        .centres    (centres[odq_pkg::REG_RED]),
        .level      (red_level)
    );

    odq_lane u_lane_green (
        .aclk       (aclk),
        .en1        (rdy1),
        .en2        (rdy2),
        .levels     (cfg.green_levels),
        .low_dither (1'b1),
        .value      (s_green_in),
        .dcell      (s_dither_cell),
        .centres    (centres[odq_pkg::REG_GREEN]),
        .level      (green_level)
    );

    // blue has no dither below its first centre
    odq_lane u_lane_blue (
        .aclk       (aclk),
        .en1        (rdy1),
        .en2        (rdy2),
        .levels     (cfg.blue_levels),
        .low_dither (1'b0),
        .value      (s_blue_in),
        .dcell      (s_dither_cell),
        .centres    (centres[odq_pkg::REG_BLUE]),
        .level      (blue_level)
    );

    odq_merge u_merge (
        .aclk        (aclk),
        .en          (rdy3),
        .cfg         (cfg),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .color_index (m_color_index)
    );

    assign m_valid = v3_reg;

endmodule
